// ----- sv/sbms_pkg.sv -----
// ============================================================================
// sbms_pkg: shared types and constants for the sorted block merge-split block
// Key and index widths, state machine types and the control bundle that
// carries merged keys from the merge engine to the output stage.
// ============================================================================
package sbms_pkg;

  // Key width and the largest block the stores can hold.
  localparam int KEY_W     = 32;
  localparam int BLOCK_MAX = 64;
  localparam int IDX_W     = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
  localparam int CNT_W     = $clog2(BLOCK_MAX + 1);

  // Values of the mode bit: which half of the merged keys is kept.
  localparam logic KEEP_LOW  = 1'b0;
  localparam logic KEEP_HIGH = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Main sequencer: load pairs, prime the key reads, merge, wait for output.
  typedef enum logic [1:0] {
    S_LOAD,
    S_PRIME,
    S_MERGE,
    S_EMIT
  } main_state_t;

  // Output stage sequencer.
  typedef enum logic [1:0] {
    E_IDLE,
    E_PRIME,
    E_RUN
  } emit_state_t;

  // Merge engine to output stage: buffer write port and start of emission.
  typedef struct packed {
    logic wr_en;
    idx_t wr_addr;
    key_t wr_data;
    logic start;
    idx_t last_idx;
  } emit_ctl_t;

endpackage

// ----- sv/sorted_block_merge_split.sv -----
// ============================================================================
// sorted_block_merge_split: merge-split step of odd-even transposition sort
// Loads a block of key pairs, merges the local and partner blocks and sends
// out the smaller or larger half in ascending order.
// ============================================================================
// Each input item carries one key of the local block and one key of the
// partner block; the item marked last ends the block (up to 64 pairs, extra
// pairs are dropped). The mode bit of the last item picks the half to keep:
// 0 keeps the N smallest keys, 1 the N largest, and on equal keys the local
// key wins. A block goes through these steps in order: the pairs are loaded
// (one item per cycle), the key reads are primed, the keys are merged at
// one key per cycle through the dual-read key memory, the kept-key buffer
// is primed and the kept keys are sent out, one per cycle while out_ready
// is high. After the last item of a block, no
// input is taken until the output stage has moved the final kept key into
// its output register.
module sorted_block_merge_split (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           mode,
  input  sbms_pkg::key_t own_key,
  input  sbms_pkg::key_t partner_key,
  input  logic           last_in,
  output logic           out_valid,
  input  logic           out_ready,
  output sbms_pkg::key_t kept_key,
  output logic           last_out
);
  import sbms_pkg::*;

  main_state_t state;
  main_state_t state_next;
  cnt_t        load_count;
  cnt_t        load_count_next;
  cnt_t        blk_n;
  logic        blk_mode;
  idx_t        pa;
  idx_t        pa_next;
  idx_t        pb;
  idx_t        pb_next;
  idx_t        step;
  idx_t        step_next;
  idx_t        last_idx;
  key_t        rd_own;
  key_t        rd_par;
  logic        in_accept;
  logic        has_room;
  logic        take_own;
  logic        emit_done;
  emit_ctl_t   ectl;
  logic [2*KEY_W-1:0] key_mem [BLOCK_MAX];

  assign in_accept = in_valid && in_ready;
  assign has_room  = (load_count < cnt_t'(BLOCK_MAX));
  assign last_idx  = idx_t'(blk_n - cnt_t'(1));

  // Keep low takes the smaller head; keep high takes the larger tail.
  assign take_own = blk_mode ? (rd_par <= rd_own) : (rd_own <= rd_par);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_accept && last_in) state_next = S_PRIME;
      end
      S_PRIME: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        if (step == last_idx) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_done) state_next = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Pointers, counters and the write side of the kept-key buffer.
  always_comb begin
    in_ready        = 1'b0;
    load_count_next = load_count;
    pa_next         = pa;
    pb_next         = pb;
    step_next       = step;
    ectl.wr_en      = 1'b0;
    ectl.wr_addr    = blk_mode ? idx_t'(last_idx - step) : step;
    ectl.wr_data    = take_own ? rd_own : rd_par;
    ectl.start      = 1'b0;
    ectl.last_idx   = last_idx;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_accept) begin
          if (last_in) begin
            load_count_next = '0;
          end else if (has_room) begin
            load_count_next = cnt_t'(load_count + 1'b1);
          end
        end
      end
      S_PRIME: begin
        pa_next   = blk_mode ? last_idx : '0;
        pb_next   = blk_mode ? last_idx : '0;
        step_next = '0;
      end
      S_MERGE: begin
        ectl.wr_en = 1'b1;
        if (take_own) begin
          pa_next = blk_mode ? idx_t'(pa - 1'b1) : idx_t'(pa + 1'b1);
        end else begin
          pb_next = blk_mode ? idx_t'(pb - 1'b1) : idx_t'(pb + 1'b1);
        end
        step_next = idx_t'(step + 1'b1);
        if (step == last_idx) ectl.start = 1'b1;
      end
      S_EMIT: begin
        step_next = step;
      end
      default: begin
        step_next = step;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
    end
  end

  // Block length, mode and merge pointers.
  always_ff @(posedge clk) begin
    if (in_accept && last_in) begin
      blk_n    <= cnt_t'(load_count + cnt_t'(has_room));
      blk_mode <= mode;
    end
    pa   <= pa_next;
    pb   <= pb_next;
    step <= step_next;
  end

  // Key memory: local key in the upper half, partner key in the lower half.
  // Two registered reads follow the next pointer values, so the heads of
  // both blocks are ready at the start of each merge cycle.
  always_ff @(posedge clk) begin
    if (in_accept && has_room) begin
      key_mem[load_count[IDX_W-1:0]] <= {own_key, partner_key};
    end
    rd_own <= key_mem[pa_next][2*KEY_W-1:KEY_W];
    rd_par <= key_mem[pb_next][KEY_W-1:0];
  end

  // Kept-key buffer and output register.
  sbms_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ectl),
    .done      (emit_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kept_key  (kept_key),
    .last_out  (last_out)
  );

endmodule

// ----- sv/sbms_emit.sv -----
// ============================================================================
// sbms_emit: kept-key buffer and output stage
// Holds the merged keys in a buffer memory at their final positions and
// sends them out in ascending position order through an output register.
// ============================================================================
module sbms_emit (
  input  logic               clk,
  input  logic               rst,
  input  sbms_pkg::emit_ctl_t ctl,
  output logic               done,
  output logic               out_valid,
  input  logic               out_ready,
  output sbms_pkg::key_t     kept_key,
  output logic               last_out
);
  import sbms_pkg::*;

  emit_state_t est;
  emit_state_t est_next;
  idx_t        e_idx;
  idx_t        e_idx_next;
  idx_t        last_idx_r;
  key_t        rd_kept;
  logic        slot_free;
  logic        load_out;
  key_t        kept_mem [BLOCK_MAX];

  // The output register can take a new item when empty or being drained.
  assign slot_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    est_next = est;
    case (est)
      E_IDLE: begin
        if (ctl.start) est_next = E_PRIME;
      end
      E_PRIME: begin
        est_next = E_RUN;
      end
      E_RUN: begin
        if (slot_free && (e_idx == last_idx_r)) est_next = E_IDLE;
      end
      default: begin
        est_next = E_IDLE;
      end
    endcase
  end

  // Read pointer and output loading.
  always_comb begin
    e_idx_next = e_idx;
    load_out   = 1'b0;
    done       = 1'b0;
    case (est)
      E_IDLE: begin
        e_idx_next = '0;
      end
      E_PRIME: begin
        e_idx_next = '0;
      end
      E_RUN: begin
        if (slot_free) begin
          load_out   = 1'b1;
          e_idx_next = idx_t'(e_idx + 1'b1);
          if (e_idx == last_idx_r) done = 1'b1;
        end
      end
      default: begin
        e_idx_next = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      est       <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      est <= est_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers and the pointer.
  always_ff @(posedge clk) begin
    e_idx <= e_idx_next;
    if (ctl.start) last_idx_r <= ctl.last_idx;
    if (load_out) begin
      kept_key <= rd_kept;
      last_out <= (e_idx == last_idx_r);
    end
  end

  // Kept-key buffer: one write port from the merge, one registered read.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) kept_mem[ctl.wr_addr] <= ctl.wr_data;
    rd_kept <= kept_mem[e_idx_next];
  end

endmodule
